// ----- hw/rtl/lcsf_pkg.sv -----
// Shared types and constants for the load-cell sample filter.
package lcsf_pkg;

    localparam int RAW_W    = 24;
    localparam int CPL_W    = 32;
    localparam int WEIGHT_W = 32;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 2 * RAW_W + WEIGHT_W;

    // Weight divider: |diff| is below 2^24 and is shifted up by 24 bits.
    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = 6;
    localparam int REM_W     = 32;

    localparam int RANGE_MIN = 100;
    localparam int RANGE_MAX = 8000000;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_SENTINEL = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_UNCAL    = 3'd3,
        STAT_CLEARED  = 3'd4
    } status_t;

    typedef enum logic {
        REG_ZERO_OFFSET   = 1'b0,
        REG_COUNTS_PER_LB = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_MUL,
        S_FILT,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture beat, read ring entry
        logic clear;     // filter reset
        logic upd;       // write sample into ring, update sum
        logic mul;       // sum magnitude times reciprocal
        logic filt;      // form filtered value
        logic prep;      // load divider
        logic div_step;  // one quotient bit
        logic out_load;  // fill output register
    } dp_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_reject;
        logic is_uncal;
        logic div_last;
    } dp_sts_t;

endpackage

// ----- hw/rtl/lcsf_ctrl.sv -----
// Controller state machine for the load-cell sample filter.
module lcsf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lcsf_pkg::dp_cmd_t cmd,
    input  lcsf_pkg::dp_sts_t sts
);
    import lcsf_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_SORT;
            end
            S_SORT: begin
                if (sts.is_clear || sts.is_reject) state_next = S_OUT;
                else                               state_next = S_MUL;
            end
            S_MUL:  state_next = S_FILT;
            S_FILT: begin
                if (sts.is_uncal) state_next = S_OUT;
                else              state_next = S_PREP;
            end
            S_PREP: state_next = S_DIV;
            S_DIV: begin
                if (sts.div_last) state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: cmd.load = s_tvalid;
            S_SORT: begin
                cmd.clear = sts.is_clear;
                cmd.upd   = !sts.is_clear && !sts.is_reject;
            end
            S_MUL:  cmd.mul      = 1'b1;
            S_FILT: cmd.filt     = 1'b1;
            S_PREP: cmd.prep     = 1'b1;
            S_DIV:  cmd.div_step = 1'b1;
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

    a_reject_short: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SORT && sts.is_reject |=> state_reg == S_OUT)
        else $error("rejected sample went through filter path");

    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && !sts.div_last |=> state_reg == S_DIV)
        else $error("divider left early");

    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear, cmd.upd, cmd.div_step, cmd.out_load, cmd.load}))
        else $error("overlapping datapath commands");

endmodule

// ----- hw/rtl/lcsf_dp.sv -----
// Datapath for the load-cell sample filter: ring, sum, average and weight divider.
module lcsf_dp #(
    parameter int FILTER_DEPTH = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lcsf_pkg::dp_cmd_t                   cmd,
    output lcsf_pkg::dp_sts_t                   sts,
    input  logic                                in_filter_reset,
    input  logic [lcsf_pkg::RAW_W-1:0]          in_raw_word,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [lcsf_pkg::CPL_W-1:0]          cfg_wdata,
    output logic [lcsf_pkg::STATUS_W-1:0]       out_status,
    output logic [lcsf_pkg::OUT_W-1:0]          out_data
);
    import lcsf_pkg::*;

    localparam int IDX_W   = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int SUM_W   = RAW_W + IDX_W;
    // Exact division by the depth: x * ceil(2^SH / D) >> SH for x below 2^SUM_W.
    localparam int SH      = SUM_W + IDX_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + longint'(FILTER_DEPTH) - 64'd1) / longint'(FILTER_DEPTH);
    localparam int DVD_W   = 2 * RAW_W;

    // configuration
    logic signed [RAW_W-1:0] zo_reg;
    logic signed [CPL_W-1:0] cpl_reg;

    // ring
    logic [RAW_W-1:0]        ring_mem [FILTER_DEPTH];
    logic [RAW_W-1:0]        rd_data_reg;
    logic                    rd_vld_reg;
    logic [FILTER_DEPTH-1:0] vld_reg;
    logic signed [RAW_W-1:0] fill_reg;
    logic [IDX_W-1:0]        wp_reg;
    logic                    full_reg;
    logic signed [SUM_W-1:0] sum_reg;

    // current beat
    logic                    clr_reg;
    status_t                 rej_reg;
    logic signed [RAW_W:0]   sample_reg;

    // average and weight
    logic [PROD_W-1:0]       prod_reg;
    logic                    sum_neg_reg;
    logic signed [RAW_W-1:0] last_filt_reg;
    logic                    diff_neg_reg;
    logic [DVD_W-1:0]        acc_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;

    logic [STATUS_W-1:0]     out_status_reg;
    logic [OUT_W-1:0]        out_data_reg;

    // combinational
    logic signed [RAW_W:0]   in_sample;
    logic [RAW_W:0]          in_mag;
    status_t                 in_rej;
    logic signed [RAW_W-1:0] old_val;
    logic signed [RAW_W-1:0] samp24;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        sum_mag;
    logic [RECIP_W-1:0]      recip_c;
    logic [RAW_W-1:0]        avg_mag;
    logic signed [RAW_W-1:0] avg_val;
    logic signed [RAW_W:0]   diff;
    logic [RAW_W:0]          diff_mag;
    logic [REM_W-1:0]        trial;
    logic [REM_W-1:0]        dsor;
    logic                    qbit;
    logic [WEIGHT_W-1:0]     weight_sat;
    logic                    uncal;
    status_t                 fin_status;
    logic [RAW_W-1:0]        fin_sample;
    logic [WEIGHT_W-1:0]     fin_weight;

    assign in_sample = -$signed({in_raw_word[RAW_W-1], in_raw_word});
    assign in_mag    = in_sample[RAW_W] ? unsigned'(-in_sample) : unsigned'(in_sample);

    always_comb begin
        in_rej = STAT_OK;
        if (in_sample == 25'sd0 || in_sample == -25'sd1 ||
            in_sample == 25'sd8388607 || in_sample == -25'sd8388608) begin
            in_rej = STAT_SENTINEL;
        end else if (in_mag < (RAW_W+1)'(RANGE_MIN) || in_mag > (RAW_W+1)'(RANGE_MAX)) begin
            in_rej = STAT_RANGE;
        end
    end

    assign uncal    = cpl_reg[CPL_W-1] || (cpl_reg == '0);
    assign old_val  = rd_vld_reg ? signed'(rd_data_reg) : fill_reg;
    assign samp24   = signed'(sample_reg[RAW_W-1:0]);
    assign sum_next = sum_reg + SUM_W'(samp24) - SUM_W'(old_val);
    assign sum_mag  = sum_reg[SUM_W-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
    assign recip_c  = RECIP_W'(RECIP);
    assign avg_mag  = prod_reg[SH +: RAW_W];
    assign avg_val  = sum_neg_reg ? -signed'(avg_mag) : signed'(avg_mag);
    assign diff     = (RAW_W+1)'(last_filt_reg) - (RAW_W+1)'(zo_reg);
    assign diff_mag = diff[RAW_W] ? unsigned'(-diff) : unsigned'(diff);

    assign dsor  = {1'b0, cpl_reg[CPL_W-2:0]};
    assign trial = {rem_reg[REM_W-2:0], acc_reg[DVD_W-1]};
    assign qbit  = (trial >= dsor);

    always_comb begin
        if (diff_neg_reg) begin
            if (acc_reg > DVD_W'(33'h080000000)) weight_sat = 32'h80000000;
            else                                weight_sat = -acc_reg[WEIGHT_W-1:0];
        end else begin
            if (acc_reg > DVD_W'(32'h7FFFFFFF)) weight_sat = 32'h7FFFFFFF;
            else                               weight_sat = acc_reg[WEIGHT_W-1:0];
        end
    end

    always_comb begin
        fin_sample = sample_reg[RAW_W-1:0];
        fin_weight = '0;
        if (clr_reg) begin
            fin_status = STAT_CLEARED;
            fin_sample = '0;
        end else if (rej_reg != STAT_OK) begin
            fin_status = rej_reg;
        end else if (uncal) begin
            fin_status = STAT_UNCAL;
        end else begin
            fin_status = STAT_OK;
            fin_weight = weight_sat;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zo_reg  <= '0;
            cpl_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_ZERO_OFFSET:   zo_reg  <= signed'(cfg_wdata[RAW_W-1:0]);
                REG_COUNTS_PER_LB: cpl_reg <= signed'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ring memory, registered read at the write position
    always_ff @(posedge aclk) begin
        if (cmd.load) rd_data_reg <= ring_mem[wp_reg];
        if (cmd.upd)  ring_mem[wp_reg] <= sample_reg[RAW_W-1:0];
    end

    // ring control: unwritten entries read as the last fill value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            fill_reg <= '0;
            wp_reg   <= '0;
            full_reg <= 1'b0;
            sum_reg  <= '0;
            last_filt_reg <= '0;
        end else begin
            if (cmd.clear) begin
                vld_reg  <= '0;
                fill_reg <= zo_reg;
                wp_reg   <= '0;
                full_reg <= 1'b0;
                sum_reg  <= SUM_W'(zo_reg * FILTER_DEPTH);
            end else if (cmd.upd) begin
                vld_reg[wp_reg] <= 1'b1;
                sum_reg <= sum_next;
                if (wp_reg == IDX_W'(FILTER_DEPTH - 1)) begin
                    wp_reg   <= '0;
                    full_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
            if (cmd.filt) last_filt_reg <= full_reg ? avg_val : samp24;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clr_reg    <= in_filter_reset;
            rej_reg    <= in_rej;
            sample_reg <= in_sample;
            rd_vld_reg <= vld_reg[wp_reg];
        end
        if (cmd.mul) begin
            prod_reg    <= sum_mag * recip_c;
            sum_neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.prep) begin
            acc_reg      <= {diff_mag[RAW_W-1:0], {RAW_W{1'b0}}};
            rem_reg      <= '0;
            cnt_reg      <= '0;
            diff_neg_reg <= diff[RAW_W];
        end else if (cmd.div_step) begin
            acc_reg <= {acc_reg[DVD_W-2:0], qbit};
            rem_reg <= qbit ? (trial - dsor) : trial;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_status_reg <= fin_status;
            out_data_reg   <= {fin_weight, last_filt_reg, fin_sample};
        end
    end

    assign sts.is_clear  = clr_reg;
    assign sts.is_reject = (rej_reg != STAT_OK);
    assign sts.is_uncal  = uncal;
    assign sts.div_last  = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;

    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= IDX_W'(FILTER_DEPTH - 1))
        else $error("ring write position past depth");

endmodule

// ----- hw/rtl/load_cell_sample_filter.sv -----
// Load-cell sample filter: rejection, moving average and Q8.24 weight scaling.
// Each beat carries a 24-bit converter word, negated and checked against the
// sentinel codes and the 100..8000000 magnitude window; good samples go into a
// FILTER_DEPTH-entry moving-average ring (raw pass-through until it has
// filled once) and the filtered value less the zero offset is divided by
// counts_per_lb into a saturated Q8.24 weight. One beat is worked at a time:
// a calibrated sample passes sort, multiply, filter, divider prep, the
// 48-step radix-2 weight divider and output; an uncalibrated one skips the
// divider, and a reject or filter reset goes from sort straight to output. A
// finished result waits in the output register while the next beat is taken.
// Configuration comes in on cfg_we/cfg_addr/cfg_wdata (0: zero offset, 1: counts
// per lb); the user must write it only while the block is idle (unenforced).
module load_cell_sample_filter #(
    parameter int FILTER_DEPTH = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] raw_word
    input  logic        s_tuser,   // [0] cmd: filter reset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [23:0] sample_counts, [47:24] filtered_counts,
                                   // [79:48] weight (Q8.24)
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import lcsf_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    lcsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lcsf_dp #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_filter_reset (s_tuser),
        .in_raw_word     (s_tdata),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .out_status      (m_tuser),
        .out_data        (m_tdata)
    );

endmodule
